FILE: sv/blar_pkg.sv
`default_nettype none
package blar_pkg;

    localparam int NUM_BUTTONS = 8;
    localparam int TIMER_BITS  = 16;

    localparam int CMD_W   = 2;
    localparam int BTN_W   = 3;
    localparam int MS_W    = 14;
    localparam int NOW_W   = 16;
    localparam int MASK_W  = 8;
    localparam int TPM_W   = 16;
    localparam int LIMIT_W = TPM_W + MS_W;
    localparam int CMP_W   = (TIMER_BITS > LIMIT_W) ? TIMER_BITS : LIMIT_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CMD_W-1:0] CMD_UPDATE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOCK_ONE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOCK_ALL = 2'd2;
    localparam logic [CMD_W-1:0] CMD_LOCK_DYN = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_MS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DYN_MAX_MS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DYN_MIN_MS   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DYN_STEP_MS  = 2'd3;

    localparam logic [TPM_W-1:0] TICKS_PER_MS_RESET = 16'd10;
    localparam logic [MS_W-1:0]  DYN_MAX_RESET      = 14'd500;
    localparam logic [MS_W-1:0]  DYN_MIN_RESET      = 14'd100;
    localparam logic [MS_W-1:0]  DYN_STEP_RESET     = 14'd50;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [BTN_W-1:0]  button;
        logic [MS_W-1:0]   lock_ms;
        logic [NOW_W-1:0]  timer_now;
        logic [MASK_W-1:0] pressed_mask;
    } in_item_t;

    typedef struct packed {
        logic [MASK_W-1:0] locked_mask;
        logic [MASK_W-1:0] timed_out_mask;
    } out_item_t;

    typedef struct packed {
        logic [MS_W-1:0] dyn_max_ms;
        logic [MS_W-1:0] dyn_min_ms;
        logic [MS_W-1:0] dyn_step_ms;
    } dyn_cfg_t;

    typedef struct packed {
        logic update;
        logic lock;
        logic dyn;
        logic pressed;
    } lane_ctrl_t;

    typedef struct packed {
        logic locked;
        logic timed_out;
    } lane_stat_t;

endpackage
`default_nettype wire

FILE: sv/blar_lane.sv
`default_nettype none
module blar_lane
    import blar_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire lane_ctrl_t            ctrl,
    input  wire logic [TIMER_BITS-1:0] now,
    input  wire logic [LIMIT_W-1:0]    limit,
    input  wire dyn_cfg_t              cfg,
    output      logic [MS_W-1:0]       dyn_next,
    output      lane_stat_t            stat_next
);

    logic                  lock_flag_reg;
    logic                  timeout_flag_reg;
    logic [TIMER_BITS-1:0] lock_start_reg;
    logic [LIMIT_W-1:0]    lock_limit_reg;
    logic [MS_W-1:0]       dynamic_time_reg;
    logic [TIMER_BITS-1:0] elapsed;
    logic                  expired;

    assign elapsed = now - lock_start_reg;
    assign expired = (lock_limit_reg != '0) &&
                     (CMP_W'(elapsed) > CMP_W'(lock_limit_reg));

    always_comb begin
        if (timeout_flag_reg && (dynamic_time_reg > cfg.dyn_min_ms)) begin
            if (dynamic_time_reg > cfg.dyn_step_ms) begin
                dyn_next = dynamic_time_reg - cfg.dyn_step_ms;
            end else begin
                dyn_next = '0;
            end
        end else begin
            dyn_next = cfg.dyn_max_ms;
        end
    end

    always_comb begin
        stat_next.locked    = lock_flag_reg;
        stat_next.timed_out = timeout_flag_reg;
        if (ctrl.lock) begin
            stat_next.locked = 1'b1;
        end else if (ctrl.update && lock_flag_reg) begin
            if (expired) begin
                stat_next.locked    = 1'b0;
                stat_next.timed_out = 1'b1;
            end else if (!ctrl.pressed) begin
                stat_next.locked    = 1'b0;
                stat_next.timed_out = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lock_flag_reg    <= 1'b0;
            timeout_flag_reg <= 1'b0;
            dynamic_time_reg <= DYN_MAX_RESET;
        end else begin
            lock_flag_reg    <= stat_next.locked;
            timeout_flag_reg <= stat_next.timed_out;
            if (ctrl.dyn) begin
                dynamic_time_reg <= dyn_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.lock) begin
            lock_start_reg <= now;
            lock_limit_reg <= limit;
        end
    end

endmodule
`default_nettype wire

FILE: sv/blar_merge.sv
`default_nettype none
module blar_merge
    import blar_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push,
    input  wire lane_stat_t stat [NUM_BUTTONS],
    output      logic       space,
    output      logic       m_valid,
    input  wire logic       m_ready,
    output      out_item_t  m_item
);

    out_item_t merged;
    out_item_t head_reg;
    out_item_t skid_reg;
    logic      head_valid_reg;
    logic      skid_valid_reg;
    logic      pop;

    always_comb begin
        merged = '0;
        for (int i = 0; i < MASK_W; i++) begin
            if (i < NUM_BUTTONS) begin
                merged.locked_mask[i]    = stat[i].locked;
                merged.timed_out_mask[i] = stat[i].timed_out;
            end
        end
    end

    assign pop     = head_valid_reg && m_ready;
    assign space   = !skid_valid_reg;
    assign m_valid = head_valid_reg;
    assign m_item  = head_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            priority if (pop && skid_valid_reg) begin
                skid_valid_reg <= 1'b0;
            end else if (pop) begin
                head_valid_reg <= push;
            end else if (push && head_valid_reg) begin
                skid_valid_reg <= 1'b1;
            end else if (push) begin
                head_valid_reg <= 1'b1;
            end else begin
                head_valid_reg <= head_valid_reg;
                skid_valid_reg <= skid_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        priority if (pop && skid_valid_reg) begin
            head_reg <= skid_reg;
        end else if (push && (pop || !head_valid_reg)) begin
            head_reg <= merged;
        end else if (push) begin
            skid_reg <= merged;
        end else begin
            head_reg <= head_reg;
        end
    end

endmodule
`default_nettype wire

FILE: sv/button_lock_autorepeat.sv
// Results are registered in the output buffer (head, or skid while head waits).
// One item per cycle while s_ready is high; each lane updates its button's lock
// state and a single shared 16x14 multiplier forms the lock limit.
// A two-entry output buffer keeps input ready while one result waits.
// Reset (aresetn low, synchronous): all buttons unlocked, timeout flags cleared,
// dynamic times at 500 ms, configuration registers at their reset values.
`default_nettype none
module button_lock_autorepeat
    import blar_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output      logic                  s_ready,
    input  wire in_item_t              s_item,
    output      logic                  m_valid,
    input  wire logic                  m_ready,
    output      out_item_t             m_item,
    input  wire logic                  cfg_wen,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [TPM_W-1:0]      ticks_per_ms_reg;
    dyn_cfg_t              dyn_cfg_reg;
    logic                  go;
    logic                  btn_ok;
    logic [MS_W-1:0]       dyn_next [NUM_BUTTONS];
    logic [MS_W-1:0]       mul_ms;
    logic [LIMIT_W-1:0]    limit;
    logic [TIMER_BITS-1:0] now;
    lane_ctrl_t            ctrl [NUM_BUTTONS];
    lane_stat_t            stat [NUM_BUTTONS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_per_ms_reg        <= TICKS_PER_MS_RESET;
            dyn_cfg_reg.dyn_max_ms  <= DYN_MAX_RESET;
            dyn_cfg_reg.dyn_min_ms  <= DYN_MIN_RESET;
            dyn_cfg_reg.dyn_step_ms <= DYN_STEP_RESET;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                CFG_TICKS_PER_MS: ticks_per_ms_reg <= cfg_wdata[TPM_W-1:0];
                CFG_DYN_MAX_MS:   dyn_cfg_reg.dyn_max_ms  <= cfg_wdata[MS_W-1:0];
                CFG_DYN_MIN_MS:   dyn_cfg_reg.dyn_min_ms  <= cfg_wdata[MS_W-1:0];
                CFG_DYN_STEP_MS:  dyn_cfg_reg.dyn_step_ms <= cfg_wdata[MS_W-1:0];
                default: ;
            endcase
        end
    end

    assign go     = s_valid && s_ready;
    assign btn_ok = int'(s_item.button) < NUM_BUTTONS;
    assign now    = TIMER_BITS'(s_item.timer_now);

    always_comb begin
        mul_ms = s_item.lock_ms;
        if ((s_item.cmd == CMD_LOCK_DYN) && btn_ok) begin
            mul_ms = dyn_next[s_item.button[$clog2(NUM_BUTTONS > 1 ? NUM_BUTTONS : 2)-1:0]];
        end
    end

    assign limit = LIMIT_W'(ticks_per_ms_reg) * LIMIT_W'(mul_ms);

    generate
        for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
            logic sel;
            logic pin;
            assign sel = btn_ok && (int'(s_item.button) == i);

            if (i < MASK_W) begin : g_pin
                assign pin = s_item.pressed_mask[i];
            end else begin : g_nopin
                assign pin = 1'b0;
            end

            always_comb begin
                ctrl[i].update  = go && (s_item.cmd == CMD_UPDATE);
                ctrl[i].lock    = go && ((s_item.cmd == CMD_LOCK_ALL) ||
                                         ((s_item.cmd == CMD_LOCK_ONE) && sel) ||
                                         ((s_item.cmd == CMD_LOCK_DYN) && sel));
                ctrl[i].dyn     = go && (s_item.cmd == CMD_LOCK_DYN) && sel;
                ctrl[i].pressed = pin;
            end

            blar_lane u_lane (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctrl      (ctrl[i]),
                .now       (now),
                .limit     (limit),
                .cfg       (dyn_cfg_reg),
                .dyn_next  (dyn_next[i]),
                .stat_next (stat[i])
            );
        end
    endgenerate

    blar_merge u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (go),
        .stat    (stat),
        .space   (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule
`default_nettype wire
